### rtl/xfse_pkg.sv
// Shared types, constants and bit-count helpers of the XOR float stream encoder.
`timescale 1ns / 1ps

package xfse_pkg;

  localparam int SampleBits  = 64;
  localparam int LeadBits    = 5;
  localparam int SizeBits    = 6;
  localparam int LeadMax     = (1 << LeadBits) - 1;
  localparam int HeaderBits  = LeadBits + SizeBits;
  localparam int CmdBits     = 2 + HeaderBits + SampleBits;
  localparam int CountBits   = $clog2(SampleBits + 1);
  localparam int LenBits     = $clog2(CmdBits + 1);
  localparam int AccBits     = CmdBits + 7;
  localparam int AccCntBits  = $clog2(AccBits + 1);
  localparam int QueueDepth  = 2;
  localparam int QueuePtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CfgBits     = 4;
  localparam logic [CfgBits-1:0] SampleBytesReset = CfgBits'(8);

  typedef struct packed {
    logic [SampleBits-1:0] sample;
    logic                  end_of_block;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       final_byte;
  } out_item_t;

  // One coded sample: left-aligned code bits, their count, block end flag.
  typedef struct packed {
    logic [CmdBits-1:0] bits;
    logic [LenBits-1:0] len;
    logic               last;
  } cmd_t;

  function automatic logic [CountBits-1:0] count_leading(logic [SampleBits-1:0] x);
    logic [CountBits-1:0] c;
    c = CountBits'(SampleBits);
    for (int i = 0; i < SampleBits; i++) begin
      if (x[i]) c = CountBits'(SampleBits - 1 - i);
    end
    return c;
  endfunction

  function automatic logic [CountBits-1:0] count_trailing(logic [SampleBits-1:0] x);
    logic [CountBits-1:0] c;
    c = CountBits'(SampleBits);
    for (int i = SampleBits - 1; i >= 0; i--) begin
      if (x[i]) c = CountBits'(i);
    end
    return c;
  endfunction

endpackage

### rtl/xfse_front.sv
// Front end: sample masking, XOR with previous sample, zero counts, form choice.
`timescale 1ns / 1ps

module xfse_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [xfse_pkg::CfgBits-1:0]  sample_bytes_i,
  input  logic                          push_i,
  output logic                          full_o,
  input  xfse_pkg::in_item_t            in_item_i,
  output logic                          cmd_push_o,
  input  logic                          cmd_full_i,
  output xfse_pkg::cmd_t                cmd_o
);

  localparam int SB = xfse_pkg::SampleBits;
  localparam int LB = xfse_pkg::LeadBits;
  localparam int ZB = xfse_pkg::SizeBits;
  localparam int CB = xfse_pkg::CountBits;
  localparam int NB = xfse_pkg::LenBits;

  logic          adv1, adv2, accept;
  logic [SB-1:0] masked;
  logic [SB-1:0] prev_q;

  logic          v1_q, last1_q;
  logic [SB-1:0] x1_q;
  logic [CB-1:0] lz_raw, tz_raw;

  logic          v2_q, last2_q, zero2_q;
  logic [SB-1:0] x2_q;
  logic [LB-1:0] lz2_q;
  logic [ZB-1:0] tz2_q;

  logic [LB-1:0] wlz_q;
  logic [ZB-1:0] wtz_q;

  logic [CB-1:0] win, blk;
  logic          reuse;

  assign adv2   = !v2_q || !cmd_full_i;
  assign adv1   = !v1_q || adv2;
  assign full_o = !adv1;
  assign accept = push_i && adv1;

  // Byte 0 always stays; byte k stays while the register is above k.
  always_comb begin
    for (int k = 0; k < SB / 8; k++) begin
      masked[8*k +: 8] = (k == 0 || sample_bytes_i > xfse_pkg::CfgBits'(k)) ?
                         in_item_i.sample[8*k +: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      prev_q <= '0;
    end else begin
      if (adv1) v1_q <= push_i;
      if (accept) prev_q <= in_item_i.end_of_block ? '0 : masked;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x1_q    <= prev_q ^ masked;
      last1_q <= in_item_i.end_of_block;
    end
  end

  assign lz_raw = xfse_pkg::count_leading(x1_q);
  assign tz_raw = xfse_pkg::count_trailing(x1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      x2_q    <= x1_q;
      last2_q <= last1_q;
      zero2_q <= (x1_q == '0);
      lz2_q   <= (lz_raw > CB'(xfse_pkg::LeadMax)) ? LB'(xfse_pkg::LeadMax) : lz_raw[LB-1:0];
      tz2_q   <= tz_raw[ZB-1:0];
    end
  end

  assign win   = CB'(SB) - CB'(wlz_q) - CB'(wtz_q);
  assign blk   = CB'(SB) - CB'(lz2_q) - CB'(tz2_q);
  assign reuse = (lz2_q >= wlz_q) && (tz2_q >= wtz_q) &&
                 (win < blk + CB'(xfse_pkg::HeaderBits));

  always_comb begin
    cmd_o.last = last2_q;
    if (zero2_q) begin
      cmd_o.bits = '0;
      cmd_o.len  = NB'(1);
    end else if (reuse) begin
      cmd_o.bits = {2'b11, x2_q << wlz_q, {xfse_pkg::HeaderBits{1'b0}}};
      cmd_o.len  = NB'(2) + NB'(win);
    end else begin
      cmd_o.bits = {2'b10, lz2_q, ZB'(blk - CB'(1)), x2_q << lz2_q};
      cmd_o.len  = NB'(2 + xfse_pkg::HeaderBits) + NB'(blk);
    end
  end

  assign cmd_push_o = v2_q && !cmd_full_i;

  // Window follows every new description; block end drops it back to reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlz_q <= '0;
      wtz_q <= '0;
    end else if (cmd_push_o) begin
      if (last2_q) begin
        wlz_q <= '0;
        wtz_q <= '0;
      end else if (!zero2_q && !reuse) begin
        wlz_q <= lz2_q;
        wtz_q <= tz2_q;
      end
    end
  end

endmodule

### rtl/xfse_queue.sv
// Short command queue between the front end and the bit packer.
`timescale 1ns / 1ps

module xfse_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  xfse_pkg::cmd_t data_i,
  input  logic           pop_i,
  output logic           empty_o,
  output xfse_pkg::cmd_t data_o
);

  localparam int PB = xfse_pkg::QueuePtrBits;
  localparam int DB = $clog2(xfse_pkg::QueueDepth + 1);

  xfse_pkg::cmd_t mem_q [xfse_pkg::QueueDepth];
  logic [PB-1:0]  wr_ptr_q, rd_ptr_q;
  logic [DB-1:0]  cnt_q;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == DB'(xfse_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [PB-1:0] next_ptr(logic [PB-1:0] p);
    return (p == PB'(xfse_pkg::QueueDepth - 1)) ? '0 : p + PB'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop) cnt_q <= cnt_q + DB'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - DB'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("command queue pushed while full");

endmodule

### rtl/xfse_pack.sv
// Bit packer: appends coded bits to the pending byte and hands out whole bytes.
`timescale 1ns / 1ps

module xfse_pack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_pop_o,
  input  xfse_pkg::cmd_t      cmd_i,
  output logic                empty_o,
  input  logic                pop_i,
  output xfse_pkg::out_item_t out_item_o
);

  localparam int AB = xfse_pkg::AccBits;
  localparam int CB = xfse_pkg::AccCntBits;

  logic [AB-1:0]       acc_q, acc_d;
  logic [CB-1:0]       cnt_q, cnt_d;
  logic                last_q, last_d;
  logic                ov_q;
  xfse_pkg::out_item_t out_q;
  logic                busy, slot_free, emit, load, fin;

  assign busy      = (cnt_q >= CB'(8)) || (last_q && cnt_q != '0);
  assign slot_free = !ov_q || pop_i;
  assign emit      = busy && slot_free;
  assign load      = !busy && cmd_valid_i;
  assign fin       = last_q && (cnt_q <= CB'(8));
  assign cmd_pop_o = load;

  always_comb begin
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    last_d = last_q;
    if (emit) begin
      acc_d = acc_q << 8;
      if (fin) begin
        cnt_d  = '0;
        last_d = 1'b0;
      end else begin
        cnt_d = cnt_q - CB'(8);
      end
    end else if (load) begin
      acc_d  = acc_q | ({cmd_i.bits, 7'b0} >> cnt_q[2:0]);
      cnt_d  = cnt_q + CB'(cmd_i.len);
      last_d = cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      cnt_q  <= '0;
      last_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      last_q <= last_d;
      if (emit) ov_q <= 1'b1;
      else if (pop_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.out_byte   <= acc_q[AB-1 -: 8];
      out_q.final_byte <= fin;
    end
  end

  assign empty_o    = !ov_q;
  assign out_item_o = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CB'(AB)) else $error("packer bit count beyond accumulator");

  a_load_partial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (cnt_q < CB'(8)) && !last_q) else $error("packer loaded while draining");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && fin) |=> (cnt_q == '0) && !last_q && (acc_q == '0))
    else $error("packer state left over after final byte");

endmodule

### rtl/xor_float_stream_encoder_core.sv
// Top level of the XOR float stream encoder: config register and block wiring.
`timescale 1ns / 1ps

// XOR float stream encoder (XOR compression of 64-bit float samples).
// Input side is a queue: drive in_item_i and raise push; the word is taken on
// a clock edge where push is high and full is low. Output side is a queue too:
// while empty is low, out_item_o holds the oldest output byte; raise pop to
// take it. final_byte marks the last byte of a block, which ends with the
// sample flagged end_of_block (the partial byte is padded with zeros).
// The sample_bytes register is written through cfg_valid_i/cfg_ready_o with
// data on cfg_data_i; ready is always high. Write it only while idle.
// A sample passes the front-end registers and the command queue before the
// packer loads it; its bytes then leave through the output register. The front
// end takes a sample per cycle while full is low; the packer loads a coded
// sample only when less than a whole byte and no block end are pending.
// Reset clears the previous sample, the zero window and the pending bits and
// sets sample_bytes to 8. A stalled receiver holds the output word; the
// two-entry command queue then fills and full rises to hold off the sender.
module xor_float_stream_encoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [xfse_pkg::CfgBits-1:0]  cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  xfse_pkg::in_item_t            in_item_i,
  output logic                          empty,
  input  logic                          pop,
  output xfse_pkg::out_item_t           out_item_o
);

  logic [xfse_pkg::CfgBits-1:0] sample_bytes_q;
  xfse_pkg::cmd_t               fq_cmd, qb_cmd;
  logic                         fq_push, fq_full;
  logic                         qb_empty, qb_pop;

  // Always take config writes; hold the value across blocks.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_bytes_q <= xfse_pkg::SampleBytesReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sample_bytes_q <= cfg_data_i;
    end
  end

  // Front end: mask, XOR, count zeros, choose the code form.
  xfse_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_bytes_i (sample_bytes_q),
    .push_i         (push),
    .full_o         (full),
    .in_item_i      (in_item_i),
    .cmd_push_o     (fq_push),
    .cmd_full_i     (fq_full),
    .cmd_o          (fq_cmd)
  );

  // Decouple front end from packer so either side can stall alone.
  xfse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .full_o  (fq_full),
    .data_i  (fq_cmd),
    .pop_i   (qb_pop),
    .empty_o (qb_empty),
    .data_o  (qb_cmd)
  );

  // Back end: pack bits MSB first, drive one byte per cycle while whole bytes are pending and the receiver pops.
  xfse_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!qb_empty),
    .cmd_pop_o   (qb_pop),
    .cmd_i       (qb_cmd),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_item_o  (out_item_o)
  );

endmodule

### bench/xfse_checker.sv
// Checker for the XOR float stream encoder: watches all channels, predicts and compares bytes.
`timescale 1ns / 1ps

module xfse_checker import xfse_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgBits-1:0] cfg_data_i,
  input  logic               push_i,
  input  logic               full_i,
  input  in_item_t           in_item_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  out_item_t          out_item_i,
  output int                 mismatch_count_o,
  output int                 waiting_bytes_o
);

  // Model state
  logic [CfgBits-1:0]    sample_bytes_q;
  logic [SampleBits-1:0] prev_sample;
  int                    win_lead;
  int                    win_trail;
  logic [7:0]            part_byte;
  int                    part_count;

  logic [7:0] step_bytes[$];
  out_item_t  expected_bytes[$];
  int         errors;

  function automatic int lead_zeros(logic [SampleBits-1:0] x);
    int c;
    c = 0;
    while (c < SampleBits && !x[SampleBits-1-c]) c++;
    return c;
  endfunction

  function automatic int trail_zeros(logic [SampleBits-1:0] x);
    int c;
    c = 0;
    while (c < SampleBits && !x[c]) c++;
    return c;
  endfunction

  task automatic clear_block();
    prev_sample = '0;
    win_lead    = 0;
    win_trail   = 0;
    part_byte   = '0;
    part_count  = 0;
  endtask

  // Append the low n bits of v, MSB first; collect every byte that completes.
  task automatic shift_in(input logic [SampleBits-1:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) begin
      part_byte[7-part_count] = v[i];
      part_count++;
      if (part_count == 8) begin
        step_bytes.push_back(part_byte);
        part_byte  = '0;
        part_count = 0;
      end
    end
  endtask

  task automatic encode_sample(input in_item_t item);
    int                    nbytes;
    int                    lead;
    int                    trail;
    int                    blk;
    int                    cost;
    int                    win;
    logic [SampleBits-1:0] s;
    logic [SampleBits-1:0] x;
    out_item_t             o;
    nbytes = int'(sample_bytes_q);
    if (nbytes < 1) nbytes = 1;
    if (nbytes > 8) nbytes = 8;
    s = item.sample;
    if (nbytes < 8) s &= (64'h1 << (8 * nbytes)) - 64'h1;
    step_bytes.delete();
    x = prev_sample ^ s;
    if (x == '0) begin
      shift_in(64'h0, 1);
    end else begin
      lead  = lead_zeros(x);
      trail = trail_zeros(x);
      shift_in(64'h1, 1);
      if (lead > LeadMax) lead = LeadMax;
      blk  = SampleBits - lead - trail;
      cost = HeaderBits + blk;
      win  = SampleBits - win_lead - win_trail;
      if (lead >= win_lead && trail >= win_trail && win < cost) begin
        shift_in(64'h1, 1);
        shift_in(x >> win_trail, win);
      end else begin
        shift_in(64'h0, 1);
        shift_in(SampleBits'(lead), LeadBits);
        shift_in(SampleBits'(blk - 1), SizeBits);
        shift_in(x >> trail, blk);
        win_lead  = lead;
        win_trail = trail;
      end
      prev_sample = s;
    end
    if (item.end_of_block) begin
      if (part_count != 0) step_bytes.push_back(part_byte);
      clear_block();
    end
    for (int i = 0; i < step_bytes.size(); i++) begin
      o.out_byte   = step_bytes[i];
      o.final_byte = item.end_of_block && (i == step_bytes.size() - 1);
      expected_bytes.push_back(o);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      sample_bytes_q = SampleBytesReset;
      clear_block();
      expected_bytes.delete();
      errors = 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (expected_bytes.size() == 0) begin
          errors++;
          $display("%0t: unexpected byte %h final %b", $time,
                   out_item_i.out_byte, out_item_i.final_byte);
        end else begin
          want = expected_bytes.pop_front();
          if (out_item_i.out_byte !== want.out_byte ||
              out_item_i.final_byte !== want.final_byte) begin
            errors++;
            $display("%0t: mismatch: expected byte %h final %b, got byte %h final %b",
                     $time, want.out_byte, want.final_byte,
                     out_item_i.out_byte, out_item_i.final_byte);
          end
        end
      end
      // A word taken on the same edge as a register write still sees the old value.
      if (push_i && !full_i) encode_sample(in_item_i);
      if (cfg_valid_i && cfg_ready_i) sample_bytes_q = cfg_data_i;
    end
    mismatch_count_o <= errors;
    waiting_bytes_o  <= expected_bytes.size();
  end

endmodule

### bench/tb_top.sv
// Stimulus and verdict for the XOR float stream encoder, with the checker beside the block.
`timescale 1ns / 1ps

module tb_top;
  import xfse_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;   // long receiver hold-off to fill the block
  localparam int DrainWait  = 16;    // pipeline depth plus margin before a config write

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgBits-1:0] cfg_data  = '0;
  logic               push      = 1'b0;
  logic               full;
  in_item_t           in_item   = '0;
  logic               empty;
  logic               pop       = 1'b0;
  out_item_t          out_item;

  int mismatches;
  int waiting;

  // Traffic shaping, set per phase by the stimulus process
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_tokens   = 0;

  // Receiver-owned hold-off bookkeeping
  int hold_taken = 0;
  int hold_left  = 0;

  int cycles = 0;
  logic [SampleBits-1:0] last_sample = '0;

  always #5 clk = ~clk;

  xor_float_stream_encoder_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item)
  );

  xfse_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .push_i           (push),
    .full_i           (full),
    .in_item_i        (in_item),
    .empty_i          (empty),
    .pop_i            (pop),
    .out_item_i       (out_item),
    .mismatch_count_o (mismatches),
    .waiting_bytes_o  (waiting)
  );

  // Receiver: stall at the phase rate; on a hold request, drop pop for a long
  // stretch counted here so the sender keeps pushing into a full block.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop       <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_tokens) begin
      hold_taken <= hold_taken + 1;
      hold_left  <= HoldCycles;
      pop        <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: end the run as failed once the cycle count passes the limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one word and hold it until the block takes it. Keep push high into
  // the next word unless a gap follows, so push never drops and rises in one step.
  task automatic send_sample(input logic [SampleBits-1:0] s, input logic eob);
    int gap;
    push    <= 1'b1;
    in_item <= '{sample: s, end_of_block: eob};
    do @(posedge clk); while (full);
    last_sample = s;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop push and wait until every predicted byte has been taken.
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_sample_bytes(input logic [CfgBits-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly slowly varying samples, so windows get reused; some repeats and
  // some fully random words for noise and bit coverage.
  function automatic logic [SampleBits-1:0] make_sample();
    int                    kind;
    int                    lo;
    int                    width;
    logic [SampleBits-1:0] mask;
    kind = $urandom_range(99);
    if (kind < 15) return last_sample;
    if (kind < 35) return {$urandom, $urandom};
    lo    = $urandom_range(0, SampleBits - 1);
    width = $urandom_range(1, (SampleBits - lo < 20) ? SampleBits - lo : 20);
    mask  = ((64'h1 << width) - 64'h1) << lo;
    return last_sample ^ ({$urandom, $urandom} & mask);
  endfunction

  task automatic run_phase(input logic [CfgBits-1:0] cfg, input int idle, input int stall,
                           input int n_items, input bit hold);
    logic eob;
    drain();
    write_sample_bytes(cfg);
    send_idle_pct = idle;
    stall_pct     = stall;
    for (int i = 0; i < n_items; i++) begin
      if (hold && i == 4) hold_tokens++;
      // End blocks at random; always close the phase so every bit drains.
      eob = (i == n_items - 1) || ($urandom_range(7) == 0);
      send_sample(make_sample(), eob);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset width of eight bytes, no idling.
    send_sample(64'h0, 1'b1);                      // zero XOR alone, padded flush
    repeat (7) send_sample(64'h0, 1'b0);           // eight zero bits fill one byte
    send_sample(64'h0, 1'b1);                      // block ends on a byte boundary
    send_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);    // initial 64-bit window reused
    send_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);    // repeat gives a zero XOR
    send_sample(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);    // one-bit block at the top
    send_sample(64'h7FFF_FFFF_FFFF_FFFE, 1'b0);    // leading count clamped
    send_sample(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);    // fits the clamped window
    send_sample(64'h7FFF_FFFF_FFFF_FFFD, 1'b1);
    send_sample(64'h8000_0000_0000_0001, 1'b0);    // full-width block
    send_sample(64'h0123_4567_89AB_CDEF, 1'b0);
    send_sample(64'hFEDC_BA98_7654_3210, 1'b1);

    // Random phases: width extremes, out-of-range widths and a random one.
    run_phase(4'd1,  0,  0,  22, 1'b1);            // long receiver hold-off here
    run_phase(4'd15, 63, 0,  22, 1'b0);
    run_phase(4'd0,  0,  63, 22, 1'b0);
    run_phase(CfgBits'($urandom_range(0, 15)), 37, 37, 22, 1'b0);
    run_phase(4'd8,  0,  0,  6,  1'b0);

    drain();
    if (mismatches == 0 && waiting == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/xfse_pkg.sv
rtl/xfse_front.sv
rtl/xfse_queue.sv
rtl/xfse_pack.sv
rtl/xor_float_stream_encoder_core.sv
bench/xfse_checker.sv
bench/tb_top.sv
